[src/kve_pkg.sv]
`timescale 1ns / 1ps
// Shared types and helpers for the k-mer vertex entry encoder.
// No dependencies.
package kve_pkg;

  // Operation applied to every cell of the code chain together
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT1,   // take the neighbor one below (cell 0 takes the new code)
    CELL_UP4,      // take the neighbor four below
    CELL_DOWN4     // take the neighbor four above
  } cell_op_e;

  // Source of the next output byte
  typedef enum logic [1:0] {
    SEL_SEQ,
    SEL_COV,
    SEL_EDGE
  } byte_sel_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_ALIGN,
    ST_SEQ,
    ST_COV,
    ST_EDGE
  } state_e;

  typedef struct packed {
    cell_op_e  op;
    byte_sel_e sel;
    logic      load;   // write the output register this cycle
    logic      last;   // byte being loaded ends the entry
  } ctl_t;

  localparam logic [7:0] AsciiC = 8'h43;
  localparam logic [7:0] AsciiG = 8'h47;
  localparam logic [7:0] AsciiT = 8'h54;

  // Unknown letters map to A
  function automatic logic [1:0] letter_to_code(input logic [7:0] s);
    logic [1:0] c;
    case (s)
      AsciiC:  c = 2'd1;
      AsciiG:  c = 2'd2;
      AsciiT:  c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] reverse_nibble(input logic [3:0] n);
    return {n[0], n[1], n[2], n[3]};
  endfunction

endpackage

[src/kmer_vertex_entry_encoder.sv]
`timescale 1ns / 1ps
// Top level of the k-mer vertex entry encoder: cell chain and output register.
// Depends on kve_pkg, kve_cell and kve_ctrl.
//
// Usage:
//   s_axis carries one ASCII nucleotide per request; tlast marks the final
//   symbol of a vertex and that request also carries coverage, edge flags
//   and the twin mode (tuser). Symbols past MAX_K are dropped, unknown
//   letters count as A.
//   m_axis returns the packed entry one byte per request: ceil(n/4)
//   sequence bytes, four little-endian coverage bytes, then the edge byte
//   with tlast set.
//   Throughput: one symbol per cycle while collecting. After the final
//   symbol the input is closed until the edge byte enters the output
//   register. Codes enter a shift chain at cell 0, so a twin entry reads
//   out from the bottom at once; a plain entry first shifts the chain up by
//   g = NCELL - n cells (NCELL = MAX_K rounded up to a multiple of four),
//   four cells per step while at least four remain, then one per step. Then
//   ceil(n/4) + 5 bytes leave, one per cycle when the receiver takes them.
//   A receiver stall holds the output byte and freezes the byte states; the
//   next vertex may start streaming while the last byte still waits.
//   Reset (rst_ni low, asynchronous) empties the output register and clears
//   the symbol count; chain contents need no reset.
module kmer_vertex_entry_encoder #(
  parameter int MAX_K = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // symbol[7:0], coverage[39:8], edge_flags[47:40]
  input  logic        s_axis_tlast,   // last_symbol
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast    // last_byte
);
  import kve_pkg::*;

  localparam int NCELL = ((MAX_K + 3) / 4) * 4;
  localparam int CW    = $clog2(NCELL + 1);

  logic          s_fire;
  logic          out_free;
  ctl_t          ctl;
  logic [CW-1:0] rem;
  logic [1:0]    cov_idx;
  logic          twin;
  logic [1:0]    new_code;
  logic [1:0]    cells [NCELL];

  logic [31:0]   coverage_q;
  logic [7:0]    edges_q;
  logic [7:0]    seq_byte;
  logic [7:0]    byte_d;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign new_code = letter_to_code(s_axis_tdata[7:0]);

  kve_ctrl #(
    .MAX_K(MAX_K),
    .NCELL(NCELL)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_fire_i   (s_fire),
    .s_last_i   (s_axis_tlast),
    .s_mode_i   (s_axis_tuser),
    .out_free_i (out_free),
    .s_ready_o  (s_axis_tready),
    .ctl_o      (ctl),
    .rem_o      (rem),
    .cov_idx_o  (cov_idx),
    .twin_o     (twin)
  );

  // Code chain: cell 0 holds the newest symbol
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic [1:0] p1, p4, n4;
    if (j == 0) begin : g_p1_in
      assign p1 = new_code;
    end else begin : g_p1_nb
      assign p1 = cells[j-1];
    end
    if (j < 4) begin : g_p4_zero
      assign p4 = 2'd0;
    end else begin : g_p4_nb
      assign p4 = cells[j-4];
    end
    if (j + 4 >= NCELL) begin : g_n4_zero
      assign n4 = 2'd0;
    end else begin : g_n4_nb
      assign n4 = cells[j+4];
    end
    kve_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (ctl.op),
      .prev1_i (p1),
      .prev4_i (p4),
      .next4_i (n4),
      .code_o  (cells[j])
    );
  end

  // Plain entry reads the top four cells, twin reads the bottom four
  // complemented; pairs past the symbol count are zero.
  always_comb begin
    seq_byte = '0;
    for (int j = 0; j < 4; j++) begin
      if (CW'(j) < rem) begin
        seq_byte[2*j +: 2] = twin ? ~cells[j] : cells[NCELL-1-j];
      end
    end
  end

  always_comb begin
    case (ctl.sel)
      SEL_SEQ:  byte_d = seq_byte;
      SEL_COV:  byte_d = coverage_q[8*cov_idx +: 8];
      SEL_EDGE: byte_d = edges_q;
      default:  byte_d = '0;
    endcase
  end

  // Vertex trailer, twin swaps parents and children with complemented index
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tlast) begin
      coverage_q <= s_axis_tdata[39:8];
      if (s_axis_tuser) begin
        edges_q <= {reverse_nibble(s_axis_tdata[43:40]),
                    reverse_nibble(s_axis_tdata[47:44])};
      end else begin
        edges_q <= s_axis_tdata[47:40];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      out_byte_q <= byte_d;
      out_last_q <= ctl.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |-> !out_valid_q || m_axis_tready)
    else $error("output byte overwritten while stalled");
  a_closed_in_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load && !ctl.last |-> !s_axis_tready)
    else $error("input open while entry bytes remain");
  a_last_is_edge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load |-> (ctl.last == (ctl.sel == SEL_EDGE)))
    else $error("last flag not on the edge byte");
`endif

endmodule

[src/kve_cell.sv]
`timescale 1ns / 1ps
// One cell of the nucleotide code chain: holds a 2-bit code.
// Depends on kve_pkg.
module kve_cell (
  input  logic               clk_i,
  input  kve_pkg::cell_op_e  op_i,
  input  logic [1:0]         prev1_i,
  input  logic [1:0]         prev4_i,
  input  logic [1:0]         next4_i,
  output logic [1:0]         code_o
);
  import kve_pkg::*;

  logic [1:0] code_q, code_d;

  always_comb begin
    case (op_i)
      CELL_SHIFT1: code_d = prev1_i;
      CELL_UP4:    code_d = prev4_i;
      CELL_DOWN4:  code_d = next4_i;
      default:     code_d = code_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign code_o = code_q;

endmodule

[src/kve_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: symbol count, chain alignment and entry byte ordering.
// Depends on kve_pkg.
module kve_ctrl #(
  parameter int MAX_K = 32,
  parameter int NCELL = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_fire_i,
  input  logic                        s_last_i,
  input  logic                        s_mode_i,
  input  logic                        out_free_i,
  output logic                        s_ready_o,
  output kve_pkg::ctl_t               ctl_o,
  output logic [$clog2(NCELL+1)-1:0]  rem_o,
  output logic [1:0]                  cov_idx_o,
  output logic                        twin_o
);
  import kve_pkg::*;

  localparam int CW = $clog2(NCELL + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] gap_q, gap_d;
  logic [1:0]    cov_idx_q, cov_idx_d;
  logic          twin_q, twin_d;
  logic          store;
  logic [CW-1:0] n_next;

  assign s_ready_o = (state_q == ST_COLLECT);
  assign store     = s_fire_i && (count_q < CW'(MAX_K));
  assign n_next    = store ? count_q + CW'(1) : count_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    gap_d     = gap_q;
    cov_idx_d = cov_idx_q;
    twin_d    = twin_q;
    ctl_o     = '{op: CELL_HOLD, sel: SEL_SEQ, load: 1'b0, last: 1'b0};

    case (state_q)
      ST_COLLECT: begin
        if (store) begin
          ctl_o.op = CELL_SHIFT1;
        end
        if (s_fire_i) begin
          count_d = n_next;
          if (s_last_i) begin
            count_d = '0;
            rem_d   = n_next;
            twin_d  = s_mode_i;
            gap_d   = CW'(NCELL) - n_next;
            if (s_mode_i || (CW'(NCELL) == n_next)) begin
              state_d = ST_SEQ;
            end else begin
              state_d = ST_ALIGN;
            end
          end
        end
      end
      ST_ALIGN: begin
        // bring the first symbol up to the top cell
        if (gap_q >= CW'(4)) begin
          ctl_o.op = CELL_UP4;
          gap_d    = gap_q - CW'(4);
        end else begin
          ctl_o.op = CELL_SHIFT1;
          gap_d    = gap_q - CW'(1);
        end
        if (gap_d == '0) begin
          state_d = ST_SEQ;
        end
      end
      ST_SEQ: begin
        ctl_o.sel = SEL_SEQ;
        if (out_free_i) begin
          ctl_o.load = 1'b1;
          ctl_o.op   = twin_q ? CELL_DOWN4 : CELL_UP4;
          rem_d      = (rem_q > CW'(4)) ? rem_q - CW'(4) : '0;
          if (rem_q <= CW'(4)) begin
            state_d   = ST_COV;
            cov_idx_d = '0;
          end
        end
      end
      ST_COV: begin
        ctl_o.sel = SEL_COV;
        if (out_free_i) begin
          ctl_o.load = 1'b1;
          cov_idx_d  = cov_idx_q + 2'd1;
          if (cov_idx_q == 2'd3) begin
            state_d = ST_EDGE;
          end
        end
      end
      ST_EDGE: begin
        ctl_o.sel = SEL_EDGE;
        if (out_free_i) begin
          ctl_o.load = 1'b1;
          ctl_o.last = 1'b1;
          state_d    = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_COLLECT;
      count_q   <= '0;
      rem_q     <= '0;
      gap_q     <= '0;
      cov_idx_q <= '0;
      twin_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      gap_q     <= gap_d;
      cov_idx_q <= cov_idx_d;
      twin_q    <= twin_d;
    end
  end

  assign rem_o     = rem_q;
  assign cov_idx_o = cov_idx_q;
  assign twin_o    = twin_q;

`ifndef SYNTHESIS
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_K))
    else $error("symbol count above MAX_K");
  a_seq_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEQ) |-> (rem_q != '0))
    else $error("sequence byte with no symbols left");
  a_align_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALIGN) |-> (gap_q != '0) && !twin_q)
    else $error("alignment with nothing to shift");
  a_edge_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDGE) && out_free_i |=> (state_q == ST_COLLECT) && (count_q == '0))
    else $error("entry end did not return to collecting");
`endif

endmodule
